FILE: src/nvw_pkg.sv
// Package for the numeric value widener: type codes and small helper functions.
// Used by numeric_value_widener; depends on nothing.
package nvw_pkg;

	localparam logic [3:0] TYPE_NONE = 4'd0;
	localparam logic [3:0] TYPE_U8   = 4'd1;
	localparam logic [3:0] TYPE_I8   = 4'd5;
	localparam logic [3:0] TYPE_I64  = 4'd8;
	localparam logic [3:0] TYPE_F32  = 4'd9;
	localparam logic [3:0] TYPE_F64  = 4'd10;

	localparam logic [3:0] REG_STORED_TYPE = 4'd0;
	localparam logic [3:0] REG_WANTED_TYPE = 4'd1;

	// Conversion kind chosen in the first stage.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_INT  = 2'd1,
		KIND_FLT  = 2'd2
	} kind_t;

	// Log2 of the size in bytes.
	function automatic logic [1:0] size_log(input logic [3:0] t);
		if (t == TYPE_F32) return 2'd2;
		if (t == TYPE_F64) return 2'd3;
		return 2'(t - TYPE_U8);
	endfunction

	function automatic logic type_ok(input logic [3:0] t);
		return (t >= TYPE_U8) && (t <= TYPE_F64);
	endfunction

	function automatic logic is_float(input logic [3:0] t);
		return (t == TYPE_F32) || (t == TYPE_F64);
	endfunction

	function automatic logic is_signed_t(input logic [3:0] t);
		return (t >= TYPE_I8) && (t <= TYPE_I64);
	endfunction

	function automatic logic [63:0] mask_of(input logic [1:0] lg);
		case (lg)
			2'd0:    return 64'h0000_0000_0000_00FF;
			2'd1:    return 64'h0000_0000_0000_FFFF;
			2'd2:    return 64'h0000_0000_FFFF_FFFF;
			default: return '1;
		endcase
	endfunction

endpackage

FILE: src/numeric_value_widener.sv
// Top level of the numeric value widener: a three-stage pipeline with valid/ready.
// Depends on nvw_pkg.
//
// One item enters per cycle while the output is not stalled. Stage one decodes
// the type pair and masks the input, stage two finds the leading one of
// an f32 denormal mantissa and sign-extends integers, stage three normalizes and
// packs the f64 result. All stages advance together whenever the output
// register is empty or being taken, so a stall at the output holds every stage
// without loss. The type registers are written through a plain write port.
module numeric_value_widener (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] stored_bits,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] widened_bits,
	output logic        no_conversion,
	output logic        last_out
);
	import nvw_pkg::*;

	logic [3:0] stored_type_q, wanted_type_q;
	logic       adv;

	logic        v_s1, v_s2, v_s3;
	kind_t       kind_s1, kind_s2;
	logic [63:0] val_s1, val_s2;
	logic [1:0]  slg_s1, wlg_s1;
	logic        sgn_s1;
	logic        last_s1, last_s2;
	logic [4:0]  lz_s2;
	logic [63:0] res_s3;
	logic        nocv_s3, last_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_type_q <= TYPE_NONE;
			wanted_type_q <= TYPE_NONE;
		end else if (cfg_we) begin
			if (cfg_index == REG_STORED_TYPE) stored_type_q <= cfg_data;
			if (cfg_index == REG_WANTED_TYPE) wanted_type_q <= cfg_data;
		end
	end

	// The whole pipe moves when the output register can take a new item.
	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	// Stage one: decide the kind of conversion.
	kind_t      kind_c;
	logic [1:0] slg_c;
	always_comb begin
		slg_c  = size_log(stored_type_q);
		kind_c = KIND_NONE;
		if (type_ok(stored_type_q) && type_ok(wanted_type_q)) begin
			if (stored_type_q == wanted_type_q) kind_c = KIND_INT;
			else if (is_float(stored_type_q) || is_float(wanted_type_q)) begin
				if (stored_type_q == TYPE_F32 && wanted_type_q == TYPE_F64)
					kind_c = KIND_FLT;
			end else if (!(is_signed_t(stored_type_q) && !is_signed_t(wanted_type_q))
					&& size_log(wanted_type_q) > slg_c)
				kind_c = KIND_INT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_c;
			val_s1  <= stored_bits & mask_of(slg_c);
			slg_s1  <= slg_c;
			wlg_s1  <= size_log(wanted_type_q);
			sgn_s1  <= is_signed_t(stored_type_q) && stored_type_q != wanted_type_q;
			last_s1 <= last_in;
		end
	end

	// Stage two: integer extension and leading-zero count of the f32 mantissa.
	logic [63:0] ext_c;
	logic [4:0]  lz_c;
	always_comb begin
		ext_c = val_s1;
		if (sgn_s1) begin
			case (slg_s1)
				2'd0: ext_c = {{56{val_s1[7]}}, val_s1[7:0]};
				2'd1: ext_c = {{48{val_s1[15]}}, val_s1[15:0]};
				2'd2: ext_c = {{32{val_s1[31]}}, val_s1[31:0]};
				default: ext_c = val_s1;
			endcase
		end
		ext_c = ext_c & mask_of(wlg_s1);
		lz_c = 5'd0;
		for (int i = 0; i < 23; i++)
			if (val_s1[i]) lz_c = 5'(22 - i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			val_s2  <= (kind_s1 == KIND_INT) ? ext_c : val_s1;
			lz_s2   <= lz_c;
			last_s2 <= last_s1;
		end
	end

	// Stage three: f32 to f64 packing and output register.
	logic [63:0] flt_c;
	logic [7:0]  ex;
	logic [22:0] man, nman;
	always_comb begin
		ex   = val_s2[30:23];
		man  = val_s2[22:0];
		nman = man << (lz_s2 + 5'd1);
		if (ex == 8'hFF) begin
			flt_c = {val_s2[31], 11'h7FF, 52'd0};
			if (man != 23'd0) flt_c = {val_s2[31], 11'h7FF, 1'b1, man[21:0], 29'd0};
		end else if (ex == 8'd0) begin
			if (man == 23'd0) flt_c = {val_s2[31], 63'd0};
			else flt_c = {val_s2[31], 11'(11'd896 - 11'(lz_s2)), nman, 29'd0};
		end else
			flt_c = {val_s2[31], 11'(11'(ex) + 11'd896), man, 29'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (kind_s2)
				KIND_INT: res_s3 <= val_s2;
				KIND_FLT: res_s3 <= flt_c;
				default:  res_s3 <= '0;
			endcase
			nocv_s3 <= (kind_s2 == KIND_NONE);
			last_s3 <= last_s2;
		end
	end

	assign out_valid     = v_s3;
	assign widened_bits  = res_s3;
	assign no_conversion = nocv_s3;
	assign last_out      = last_s3;

	// A refused conversion always carries a zero value.
	a_nocv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_conversion) |-> (widened_bits == 64'd0))
		else $error("no_conversion item with nonzero value");

	// An accepted item shows up at the output once the pipe has moved it through stages one, two and three.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("item lost in pipeline");

	// A stalled output holds its item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(widened_bits)))
		else $error("stalled result changed");

endmodule
